@@ rtl/core/qrs_pkg.sv @@
// Shared types and codes for the quadratic root solver.
`default_nettype none
package qrs_pkg;

	// One input beat: two polynomials of degree at most two.
	typedef struct packed {
		logic [2:0]         first_deg;
		logic signed [31:0] first_c0;
		logic signed [31:0] first_c1;
		logic signed [31:0] first_c2;
		logic [2:0]         second_deg;
		logic signed [31:0] second_c0;
		logic signed [31:0] second_c1;
		logic signed [31:0] second_c2;
	} qrs_in_t;

	// One result beat.
	typedef struct packed {
		logic [1:0]         root_count;
		logic signed [31:0] root_one;
		logic signed [31:0] root_two;
		logic               unsupported_degree;
		logic               root_overflow;
	} qrs_out_t;

	// Solve class, refined by the back end once the discriminant is known.
	typedef enum logic [2:0] {
		KIND_UNS  = 3'd0,
		KIND_NONE = 3'd1,
		KIND_LIN  = 3'd2,
		KIND_QUAD = 3'd3,
		KIND_ONE  = 3'd4,
		KIND_TWO  = 3'd5
	} kind_t;

	// Classified job: difference polynomial a*x^2 + b*x + c.
	typedef struct packed {
		kind_t              kind;
		logic signed [32:0] a;
		logic signed [32:0] b;
		logic signed [32:0] c;
	} qrs_job_t;

	localparam logic [15:0] EPS_RESET = 16'd1;

endpackage
`default_nettype wire

@@ rtl/core/qrs_front.sv @@
// Front end: eps register, coefficient difference and solve classification.
`default_nettype none
module qrs_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [15:0]      cfg_wdata,
	input  wire qrs_pkg::qrs_in_t item,
	output qrs_pkg::qrs_job_t     job,
	output logic [15:0]           eps
);
	import qrs_pkg::*;

	logic [15:0]        eps_q;
	logic               swap;
	logic [2:0]         deg;
	logic signed [32:0] f0, f1, f2, s0, s1, s2;
	logic signed [32:0] e0, e1, e2;

	function automatic logic tiny(logic signed [32:0] v, logic [15:0] th);
		logic [32:0] m;
		m = v[32] ? 33'(-v) : 33'(v);
		return (v == '0) || (m < {17'd0, th});
	endfunction

	// Threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (cfg_we) begin
			eps_q <= cfg_wdata;
		end
	end
	assign eps = eps_q;

	// Mask coefficients above the declared degree, subtract lower from higher
	always_comb begin
		swap = item.second_deg > item.first_deg;
		deg  = swap ? item.second_deg : item.first_deg;
		f0 = 33'(item.first_c0);
		f1 = (item.first_deg >= 3'd1) ? 33'(item.first_c1) : '0;
		f2 = (item.first_deg >= 3'd2) ? 33'(item.first_c2) : '0;
		s0 = 33'(item.second_c0);
		s1 = (item.second_deg >= 3'd1) ? 33'(item.second_c1) : '0;
		s2 = (item.second_deg >= 3'd2) ? 33'(item.second_c2) : '0;
		e0 = swap ? s0 - f0 : f0 - s0;
		e1 = swap ? s1 - f1 : f1 - s1;
		e2 = swap ? s2 - f2 : f2 - s2;
	end

	// Classify
	always_comb begin
		job.a = e2;
		job.b = e1;
		job.c = e0;
		if (deg == 3'd0 || deg > 3'd2) begin
			job.kind = KIND_UNS;
		end else if (deg == 3'd1 || tiny(e2, eps_q)) begin
			job.kind = tiny(e1, eps_q) ? KIND_NONE : KIND_LIN;
		end else begin
			job.kind = KIND_QUAD;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/qrs_fifo.sv @@
// Short job queue between front and back end.
`default_nettype none
module qrs_fifo #(
	parameter int DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr,
	input  wire qrs_pkg::qrs_job_t wdata,
	output logic                   full,
	input  wire logic              rd,
	output qrs_pkg::qrs_job_t      rdata,
	output logic                   empty
);
	import qrs_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	qrs_job_t      mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr, do_rd;

	assign full  = cnt_q == CW'(DEPTH);
	assign empty = cnt_q == '0;
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rp_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH)) else $error("queue count beyond depth");
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> wp_q == rp_q) else $error("empty queue with pointers apart");
	a_full_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> wp_q == rp_q) else $error("full queue with pointers apart");

endmodule
`default_nettype wire

@@ rtl/core/qrs_back.sv @@
// Back end: discriminant, pipelined square root, two pipelined dividers.
`default_nettype none
module qrs_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [15:0]       eps,
	input  wire logic              job_avail,
	input  wire qrs_pkg::qrs_job_t job,
	output logic                   job_take,
	output logic                   empty,
	input  wire logic              pop,
	output qrs_pkg::qrs_out_t      result
);
	import qrs_pkg::*;

	localparam int SQ_N = 36;
	localparam int DV_N = 32;
	localparam int NST  = 2 + SQ_N + DV_N + 2;

	typedef struct packed {
		kind_t              kind;
		logic signed [32:0] a, b, c;
		logic [65:0]        bb, ac;
		logic               add;
	} mul_t;

	typedef struct packed {
		kind_t              kind;
		logic signed [32:0] a, b, c;
		logic [71:0]        rad;
		logic [39:0]        rem;
		logic [35:0]        root;
	} sq_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] q1, q2;
		logic [36:0] r1, r2;
		logic [31:0] lo1, lo2;
		logic [35:0] dm;
		logic        neg1, neg2, big1, big2;
	} dv_t;

	mul_t           mul_s1;
	sq_t            disc_s2;
	sq_t            sq_s3 [SQ_N];
	dv_t            dv_s4 [DV_N + 1];
	qrs_out_t       res_s5;
	logic [NST-1:0] vld_q;
	logic           adv, take;

	function automatic logic [32:0] mag33(logic signed [32:0] v);
		return v[32] ? 33'(-v) : 33'(v);
	endfunction

	function automatic logic [35:0] mag37(logic signed [36:0] v);
		logic signed [36:0] m;
		m = v[36] ? -v : v;
		return m[35:0];
	endfunction

	// One root digit per step
	function automatic sq_t sq_step(sq_t x);
		sq_t         y;
		logic [39:0] pre, trial;
		y     = x;
		pre   = {x.rem[37:0], x.rad[71:70]};
		trial = {2'b00, x.root, 2'b01};
		y.rad = {x.rad[69:0], 2'b00};
		if (pre >= trial) begin
			y.rem  = pre - trial;
			y.root = {x.root[34:0], 1'b1};
		end else begin
			y.rem  = pre;
			y.root = {x.root[34:0], 1'b0};
		end
		return y;
	endfunction

	// Numerators, divisor, overflow precheck, first partial remainder
	function automatic dv_t dv_setup(sq_t x);
		dv_t                y;
		logic signed [36:0] n1, n2, d, bx, sx, a2;
		logic [35:0]        nm1, nm2;
		bx = 37'(x.b);
		sx = $signed({1'b0, x.root});
		a2 = $signed({{3{x.a[32]}}, x.a, 1'b0});
		n1 = '0;
		n2 = '0;
		d  = '0;
		case (x.kind)
			KIND_LIN: begin
				n1 = -37'(x.c);
				d  = bx;
			end
			KIND_ONE: begin
				n1 = -bx;
				d  = a2;
			end
			KIND_TWO: begin
				n1 = -bx - sx;
				n2 = -bx + sx;
				d  = a2;
			end
			default: begin
				d = '0;
			end
		endcase
		nm1    = mag37(n1);
		nm2    = mag37(n2);
		y.kind = x.kind;
		y.dm   = mag37(d);
		y.q1   = '0;
		y.q2   = '0;
		y.neg1 = n1[36] != d[36];
		y.neg2 = n2[36] != d[36];
		y.big1 = {16'd0, nm1} >= {y.dm, 16'd0};
		y.big2 = {16'd0, nm2} >= {y.dm, 16'd0};
		y.r1   = {17'd0, nm1[35:16]};
		y.r2   = {17'd0, nm2[35:16]};
		y.lo1  = {nm1[15:0], 16'd0};
		y.lo2  = {nm2[15:0], 16'd0};
		return y;
	endfunction

	// One quotient bit per lane
	function automatic dv_t dv_step(dv_t x);
		dv_t         y;
		logic [36:0] p1, p2, dd;
		y  = x;
		dd = {1'b0, x.dm};
		p1 = {x.r1[35:0], x.lo1[31]};
		p2 = {x.r2[35:0], x.lo2[31]};
		y.lo1 = {x.lo1[30:0], 1'b0};
		y.lo2 = {x.lo2[30:0], 1'b0};
		y.r1  = (p1 >= dd) ? p1 - dd : p1;
		y.r2  = (p2 >= dd) ? p2 - dd : p2;
		y.q1  = {x.q1[30:0], p1 >= dd};
		y.q2  = {x.q2[30:0], p2 >= dd};
		return y;
	endfunction

	// Sign and saturation: {overflow, root}
	function automatic logic [32:0] fin(logic [31:0] q, logic neg, logic big);
		logic [32:0] r;
		if (big) begin
			r = neg ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
		end else if (!neg) begin
			r = (q > 32'h7FFF_FFFF) ? {1'b1, 32'h7FFF_FFFF} : {1'b0, q};
		end else begin
			r = (q > 32'h8000_0000) ? {1'b1, 32'h8000_0000} : {1'b0, 32'(-q)};
		end
		return r;
	endfunction

	function automatic qrs_out_t build(dv_t x);
		qrs_out_t    o;
		logic [32:0] f1, f2;
		f1 = fin(x.q1, x.neg1, x.big1);
		f2 = fin(x.q2, x.neg2, x.big2);
		o  = '0;
		case (x.kind)
			KIND_UNS: begin
				o.unsupported_degree = 1'b1;
			end
			KIND_LIN, KIND_ONE: begin
				o.root_count    = 2'd1;
				o.root_one      = $signed(f1[31:0]);
				o.root_overflow = f1[32];
			end
			KIND_TWO: begin
				o.root_count    = 2'd2;
				o.root_one      = $signed(f1[31:0]);
				o.root_two      = $signed(f2[31:0]);
				o.root_overflow = f1[32] | f2[32];
			end
			default: begin
				o.root_count = 2'd0;
			end
		endcase
		return o;
	endfunction

	// Whole pipeline moves together; the output stage is the last register
	assign adv      = !vld_q[NST-1] || pop;
	assign take     = adv && job_avail;
	assign job_take = take;
	assign empty    = !vld_q[NST-1];
	assign result   = res_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], take};
		end
	end

	// Stage 1: squares and products of magnitudes
	always_ff @(posedge clk) begin
		if (adv) begin
			mul_s1.kind <= job.kind;
			mul_s1.a    <= job.a;
			mul_s1.b    <= job.b;
			mul_s1.c    <= job.c;
			mul_s1.bb   <= mag33(job.b) * mag33(job.b);
			mul_s1.ac   <= mag33(job.a) * mag33(job.c);
			mul_s1.add  <= (job.c == '0) || (job.a[32] != job.c[32]);
		end
	end

	// Stage 2: discriminant and final class
	logic [67:0] bb_x, f_x, d_x;
	logic        dneg;
	always_comb begin
		bb_x = {2'b00, mul_s1.bb};
		f_x  = {mul_s1.ac, 2'b00};
		dneg = !mul_s1.add && (bb_x < f_x);
		d_x  = mul_s1.add ? bb_x + f_x : bb_x - f_x;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			disc_s2.a    <= mul_s1.a;
			disc_s2.b    <= mul_s1.b;
			disc_s2.c    <= mul_s1.c;
			disc_s2.rad  <= {4'd0, d_x};
			disc_s2.rem  <= '0;
			disc_s2.root <= '0;
			if (mul_s1.kind != KIND_QUAD) begin
				disc_s2.kind <= mul_s1.kind;
			end else if (dneg) begin
				disc_s2.kind <= KIND_NONE;
			end else if (d_x < {36'd0, eps, 16'd0}) begin
				disc_s2.kind <= KIND_ONE;
			end else begin
				disc_s2.kind <= KIND_TWO;
			end
		end
	end

	// Square root stages, then divider stages, then output register
	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s3[0] <= sq_step(disc_s2);
			for (int j = 1; j < SQ_N; j++) begin
				sq_s3[j] <= sq_step(sq_s3[j-1]);
			end
			dv_s4[0] <= dv_setup(sq_s3[SQ_N-1]);
			for (int k = 1; k <= DV_N; k++) begin
				dv_s4[k] <= dv_step(dv_s4[k-1]);
			end
			res_s5 <= build(dv_s4[DV_N]);
		end
	end

	a_uns_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.unsupported_degree) |->
		(result.root_count == 2'd0 && !result.root_overflow))
		else $error("unsupported beat carries roots");
	a_no_root_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.root_count == 2'd0) |->
		(result.root_one == '0 && result.root_two == '0 && !result.root_overflow))
		else $error("rootless beat with nonzero roots");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.root_count != 2'd3) else $error("root count out of range");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> $stable(vld_q)) else $error("pipeline moved while stalled");

endmodule
`default_nettype wire

@@ rtl/core/quadratic_root_solver.sv @@
// Top level of the quadratic root solver.
//
//  channel | dir | handshake          | beat
//  --------+-----+--------------------+-----------------------------
//  item    | in  | push / full        | qrs_in_t: two polynomials
//  result  | out | empty / pop        | qrs_out_t: count, roots, flags
//  cfg     | in  | cfg_we             | cfg_wdata: eps threshold
//
// One item per cycle sustained while results are popped and the queue is not full. An
// accepted item passes through the job queue, then a product stage, a discriminant stage, 36 square-root
// stages, a divider setup stage, 32 divider stages (both roots in parallel
// lanes) and the output register. The job queue (FIFO_DEPTH entries) decouples the front
// from the back, so pushes continue while the result side stalls until the
// queue fills. Reset clears eps to 1 and empties the queue and pipeline.
`default_nettype none
module quadratic_root_solver #(
	parameter int FIFO_DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire qrs_pkg::qrs_in_t item,
	output logic                  empty,
	input  wire logic             pop,
	output qrs_pkg::qrs_out_t     result,
	input  wire logic             cfg_we,
	input  wire logic [15:0]      cfg_wdata
);
	import qrs_pkg::*;

	qrs_job_t    job_f, job_b;
	logic [15:0] eps;
	logic        q_empty, take;

	qrs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item),
		.job       (job_f),
		.eps       (eps)
	);

	qrs_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (push),
		.wdata  (job_f),
		.full   (full),
		.rd     (take),
		.rdata  (job_b),
		.empty  (q_empty)
	);

	qrs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.eps       (eps),
		.job_avail (!q_empty),
		.job       (job_b),
		.job_take  (take),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule
`default_nettype wire
